### design/sds_pkg.sv
// Shared types and constants for the SCAN disk scheduler.
// No dependencies; every other design file uses this package.
package sds_pkg;

	localparam int CYLINDERS    = 200;
	localparam int MAX_REQUESTS = 32;

	localparam int TRK_W   = 8;
	localparam int TOTAL_W = 9;
	localparam int IDX_W   = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
	localparam int COUNT_W = $clog2(MAX_REQUESTS + 1);

	localparam logic [TRK_W-1:0] END_HIGH =
		((CYLINDERS - 1) > 255) ? TRK_W'(255) : TRK_W'(CYLINDERS - 1);
	localparam logic [TRK_W-1:0] END_LOW = '0;

	localparam int CFG_ADDR_W = 1;
	localparam int CFG_DATA_W = 8;

	typedef enum logic [CFG_ADDR_W-1:0] {
		CFG_START_HEAD = 1'b0,
		CFG_SWEEP_DIR  = 1'b1
	} cfg_addr_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WAIT,
		ST_RESOLVE,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic [TRK_W-1:0]   track;
		logic [TRK_W-1:0]   move;
		logic [TOTAL_W-1:0] total;
		logic               last;
	} visit_t;

	function automatic logic [TRK_W-1:0] clamp_cyl(input logic [TRK_W-1:0] v);
		return (v > END_HIGH) ? END_HIGH : v;
	endfunction

endpackage

### design/sds_ifs.sv
// Handshake channels of the SCAN disk scheduler: requests, visits, config writes.
// Depends on sds_pkg for field widths.
interface sds_req_if;
	logic                          valid;
	logic                          ready;
	logic [sds_pkg::TRK_W-1:0]     request_track;
	logic                          request_last;

	modport source (output valid, request_track, request_last, input ready);
	modport sink   (input valid, request_track, request_last, output ready);
endinterface

interface sds_visit_if;
	logic                          valid;
	logic                          ready;
	logic [sds_pkg::TRK_W-1:0]     served_track;
	logic [sds_pkg::TRK_W-1:0]     move_distance;
	logic [sds_pkg::TOTAL_W-1:0]   seek_total;
	logic                          sequence_last;

	modport source (output valid, served_track, move_distance, seek_total, sequence_last,
		input ready);
	modport sink   (input valid, served_track, move_distance, seek_total, sequence_last,
		output ready);
endinterface

interface sds_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [sds_pkg::CFG_ADDR_W-1:0]  addr;
	logic [sds_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, addr, data, input ready);
	modport sink   (input valid, addr, data, output ready);
endinterface

### design/scan_disk_scheduler.sv
// SCAN (elevator) disk scheduler: request store, selection scan and visit output.
// Depends on sds_pkg and the channel interfaces in sds_ifs.sv.
//
// Usage:
//   request : one cylinder request per word; request_last closes the batch.
//             Requests are written into a 32-entry store, one per cycle.
//             Requests beyond the store depth are ignored, but their last mark
//             still starts the walk. Values above the top cylinder saturate.
//   visit   : SCAN service order, one word per visited cylinder including the
//             end cylinder of the first sweep; sequence_last marks the final one.
//   cfg     : start_head (addr 0) and sweep_toward_high (addr 1), always ready.
//             Write only while no batch is in flight.
// Walk: each visit comes from one pass over the stored requests through the
//   single read port of the store. A batch with V visits takes V + 1 passes
//   and then a flush step.
//   Request ready is low from the last word until the final visit is loaded
//   into the output register.
// One visit is held back in a lookahead register so that the last mark can be
//   set once the final pass finds nothing. A stalled receiver holds the output
//   register and the walk waits for it.
// Reset clears the count, the served bits, config and the output valid; the
//   store contents need no clearing since only written entries are read.
module scan_disk_scheduler (
	input  logic              clk,
	input  logic              arst_n,
	sds_req_if.sink           request,
	sds_visit_if.source       visit,
	sds_cfg_if.sink           cfg
);

	// Config registers
	logic [sds_pkg::TRK_W-1:0]   start_head_q;
	logic                        sweep_high_q;

	// Request store
	logic [sds_pkg::TRK_W-1:0]   mem_q [sds_pkg::MAX_REQUESTS];
	logic [sds_pkg::COUNT_W-1:0] count_q;
	logic [sds_pkg::MAX_REQUESTS-1:0] served_q;

	// Walk state
	sds_pkg::state_t             state_q, state_d;
	logic [sds_pkg::TRK_W-1:0]   start_q;
	logic                        dir_q;
	logic                        phase_q;
	logic [sds_pkg::TRK_W-1:0]   head_q;
	logic [sds_pkg::TOTAL_W-1:0] total_q;
	logic [sds_pkg::COUNT_W-1:0] rd_idx_q;

	// Read stage
	logic                        rd_v_s1;
	logic [sds_pkg::IDX_W-1:0]   rd_idx_s1;
	logic [sds_pkg::TRK_W-1:0]   rd_data_s1;

	// Best candidate of the current pass
	logic                        best_v_q;
	logic [sds_pkg::TRK_W-1:0]   best_val_q;
	logic [sds_pkg::IDX_W-1:0]   best_idx_q;

	// Lookahead and output registers
	logic                        pend_v_q;
	sds_pkg::visit_t             pend_q;
	logic                        out_v_q;
	sds_pkg::visit_t             out_q;
	sds_pkg::visit_t             push_word;

	logic                        req_acc;
	logic                        slot_free;
	logic                        side_high;
	logic                        cand;
	logic [sds_pkg::TRK_W-1:0]   cyl_sel;
	logic [sds_pkg::TRK_W-1:0]   move_dist;
	logic [sds_pkg::TOTAL_W-1:0] total_next;
	logic                        place;
	logic                        push;
	logic                        push_last;
	logic                        start_walk;

	assign req_acc   = request.valid && request.ready;
	assign slot_free = !out_v_q || visit.ready;
	assign side_high = dir_q ^ phase_q;
	assign cfg.ready = 1'b1;

	// Candidate test for the word coming out of the store
	always_comb begin
		cand = rd_v_s1 && !served_q[rd_idx_s1];
		if (side_high) begin
			cand = cand && (rd_data_s1 > start_q) && (!best_v_q || rd_data_s1 < best_val_q);
		end else begin
			cand = cand && (rd_data_s1 < start_q) && (!best_v_q || rd_data_s1 > best_val_q);
		end
	end

	// Next visit: the pass winner, or the sweep end once the first side is empty
	always_comb begin
		if (best_v_q) begin
			cyl_sel = best_val_q;
		end else if (dir_q) begin
			cyl_sel = sds_pkg::END_HIGH;
		end else begin
			cyl_sel = sds_pkg::END_LOW;
		end
		move_dist  = (cyl_sel > head_q) ? (cyl_sel - head_q) : (head_q - cyl_sel);
		total_next = total_q + {1'b0, move_dist};
	end

	// Word leaving the lookahead, with the last mark set on the final one
	always_comb begin
		push_word      = pend_q;
		push_word.last = push_last;
	end

	// Next state and handshake decisions
	always_comb begin
		state_d    = state_q;
		request.ready = 1'b0;
		place      = 1'b0;
		push       = 1'b0;
		push_last  = 1'b0;
		start_walk = 1'b0;
		case (state_q)
			sds_pkg::ST_IDLE: begin
				request.ready = 1'b1;
				if (req_acc && request.request_last) begin
					start_walk = 1'b1;
					state_d    = sds_pkg::ST_SCAN;
				end
			end
			sds_pkg::ST_SCAN: begin
				if (rd_idx_q + sds_pkg::COUNT_W'(1) == count_q) begin
					state_d = sds_pkg::ST_WAIT;
				end
			end
			sds_pkg::ST_WAIT: begin
				state_d = sds_pkg::ST_RESOLVE;
			end
			sds_pkg::ST_RESOLVE: begin
				if (best_v_q || !phase_q) begin
					if (!pend_v_q || slot_free) begin
						place   = 1'b1;
						push    = pend_v_q;
						state_d = sds_pkg::ST_SCAN;
					end
				end else begin
					state_d = sds_pkg::ST_FLUSH;
				end
			end
			sds_pkg::ST_FLUSH: begin
				if (slot_free) begin
					push      = 1'b1;
					push_last = 1'b1;
					state_d   = sds_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sds_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sds_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Store write on accept, registered read for the scan
	always_ff @(posedge clk) begin
		if (req_acc && count_q < sds_pkg::COUNT_W'(sds_pkg::MAX_REQUESTS)) begin
			mem_q[count_q[sds_pkg::IDX_W-1:0]] <= sds_pkg::clamp_cyl(request.request_track);
		end
		rd_data_s1 <= mem_q[rd_idx_q[sds_pkg::IDX_W-1:0]];
		rd_idx_s1  <= rd_idx_q[sds_pkg::IDX_W-1:0];
	end

	// Config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_head_q <= '0;
			sweep_high_q <= 1'b0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.addr)
				sds_pkg::CFG_START_HEAD: start_head_q <= cfg.data;
				sds_pkg::CFG_SWEEP_DIR:  sweep_high_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// Walk control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			served_q <= '0;
			rd_idx_q <= '0;
			rd_v_s1  <= 1'b0;
			best_v_q <= 1'b0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
			phase_q  <= 1'b0;
		end else begin
			rd_v_s1 <= (state_q == sds_pkg::ST_SCAN);

			// Count requests until the store fills
			if (req_acc && count_q < sds_pkg::COUNT_W'(sds_pkg::MAX_REQUESTS)) begin
				count_q <= count_q + sds_pkg::COUNT_W'(1);
			end

			if (state_q == sds_pkg::ST_SCAN) begin
				rd_idx_q <= rd_idx_q + sds_pkg::COUNT_W'(1);
			end
			if (cand) begin
				best_v_q <= 1'b1;
			end

			if (start_walk) begin
				rd_idx_q <= '0;
				best_v_q <= 1'b0;
				pend_v_q <= 1'b0;
				phase_q  <= 1'b0;
				served_q <= '0;
			end

			// Retire the pass winner (or turn to the second side) and restart the scan
			if (place) begin
				pend_v_q <= 1'b1;
				rd_idx_q <= '0;
				best_v_q <= 1'b0;
				if (best_v_q) begin
					served_q[best_idx_q] <= 1'b1;
				end else begin
					phase_q <= 1'b1;
				end
			end

			if (push) begin
				out_v_q <= 1'b1;
			end else if (visit.ready) begin
				out_v_q <= 1'b0;
			end

			// Drop the batch once the final visit leaves the lookahead
			if (push_last) begin
				count_q  <= '0;
				served_q <= '0;
				pend_v_q <= 1'b0;
			end
		end
	end

	// Walk payload
	always_ff @(posedge clk) begin
		if (cand) begin
			best_val_q <= rd_data_s1;
			best_idx_q <= rd_idx_s1;
		end
		if (start_walk) begin
			start_q <= sds_pkg::clamp_cyl(start_head_q);
			head_q  <= sds_pkg::clamp_cyl(start_head_q);
			dir_q   <= sweep_high_q;
			total_q <= '0;
		end
		if (place) begin
			pend_q.track <= cyl_sel;
			pend_q.move  <= move_dist;
			pend_q.total <= total_next;
			pend_q.last  <= 1'b0;
			head_q       <= cyl_sel;
			total_q      <= total_next;
		end
		if (push) begin
			out_q <= push_word;
		end
	end

	assign visit.valid         = out_v_q;
	assign visit.served_track  = out_q.track;
	assign visit.move_distance = out_q.move;
	assign visit.seek_total    = out_q.total;
	assign visit.sequence_last = out_q.last;

`ifndef SYNTHESIS
	a_busy_has_requests: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != sds_pkg::ST_IDLE |-> count_q != '0)
		else $error("walk running over an empty store");

	a_winner_unserved: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sds_pkg::ST_RESOLVE && best_v_q) |-> !served_q[best_idx_q])
		else $error("pass picked an already served request");

	a_total_covers_move: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> (out_q.total >= sds_pkg::TOTAL_W'(out_q.move)))
		else $error("seek total below move distance");

	a_track_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> out_q.track <= sds_pkg::END_HIGH)
		else $error("visited track beyond end cylinder");
`endif

endmodule
